>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Slot and command structures, field widths and the operation codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned PRIO_W      = 2;
  localparam int unsigned OCC_W       = 9;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Contents of one slot of the chain.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } slot_t;

  // Broadcast command to every cell.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cmd_t;

endpackage

>>> rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the stable priority queue
// Carries one insert or remove word under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] proc_id;
  logic [1:0] prio_class;

  modport source (output valid, output kind, output proc_id, output prio_class,
                  input ready);
  modport sink   (input valid, input kind, input proc_id, input prio_class,
                  output ready);
endinterface

>>> rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the stable priority queue
// Carries one result word under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] head_id;
  logic [1:0] status;
  logic [8:0] occupancy;

  modport source (output valid, output head_id, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input head_id, input status, input occupancy,
                  output ready);
endinterface

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry and, per command, keeps it, loads the new entry or takes
// the entry of a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  slot_t prev_i,
  input  logic  prev_place_i,
  input  slot_t next_i,
  output slot_t slot_o,
  output logic  place_o
);

  logic              valid_q, valid_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [ID_W-1:0]   id_q, id_d;

  // The new entry belongs at or ahead of this slot when the slot is empty or
  // holds a strictly lower class. Along a sorted chain this flag is monotone.
  assign place_o = !valid_q || (cmd_i.prio > prio_q);
  assign slot_o  = '{valid: valid_q, prio: prio_q, id: id_q};

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    id_d    = id_q;
    if (cmd_i.pop) begin
      valid_d = next_i.valid;
      prio_d  = next_i.prio;
      id_d    = next_i.id;
    end else if (cmd_i.push) begin
      if (prev_place_i) begin
        valid_d = prev_i.valid;
        prio_d  = prev_i.prio;
        id_d    = prev_i.id;
      end else if (place_o) begin
        valid_d = 1'b1;
        prio_d  = cmd_i.prio;
        id_d    = cmd_i.id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    id_q   <= id_d;
  end

endmodule

>>> rtl/spq_chain.sv
// ----------------------------------------------------------------------------
// spq_chain: row of queue cells
// Links QUEUE_DEPTH cells to their neighbors; cell zero is the head.
// ----------------------------------------------------------------------------
module spq_chain
  import spq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output slot_t head_o
);

  slot_t slots [QUEUE_DEPTH];
  logic  place [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    slot_t prev_slot, next_slot;
    logic  prev_place;

    if (g == 0) begin : g_head
      assign prev_slot  = '0;
      assign prev_place = 1'b0;
    end else begin : g_body
      assign prev_slot  = slots[g-1];
      assign prev_place = place[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slots[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .prev_i       (prev_slot),
      .prev_place_i (prev_place),
      .next_i       (next_slot),
      .slot_o       (slots[g]),
      .place_o      (place[g])
    );
  end

  assign head_o = slots[0];

endmodule

>>> rtl/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit: sorted insert priority queue on a cell chain
// The response word appears in the cycle after its request word is accepted;
// one word per cycle while the response side takes them. Reset empties the
// queue and the response register; entry payload is not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  // The queue is a chain of QUEUE_DEPTH cells, each holding one entry. Every
  // cell compares the broadcast class against its own entry in parallel, so
  // the insert position is found without any search. On an insert the cells
  // from that position on shift one slot toward the tail; on a remove the
  // whole chain shifts one slot toward the head, both in the same clock edge.

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [ID_W-1:0]  head_id_q, head_id_d;
  status_e          status_q, status_d;
  logic [OCC_W-1:0] occ_q;

  logic  accept;
  logic  is_remove;
  logic  full, empty;
  cmd_t  cmd;
  slot_t head;

  // A new word is taken whenever the response register is free or is being
  // emptied in this same cycle.
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_remove   = (kind_e'(req_i.kind) == KIND_REMOVE);

  assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // Inserts into a full queue and removes from an empty one leave the chain
  // untouched and only report their status.
  always_comb begin
    cmd.push = accept && !is_remove && !full;
    cmd.pop  = accept && is_remove && !empty;
    cmd.prio = req_i.prio_class;
    cmd.id   = req_i.proc_id;
  end

  always_comb begin
    count_d   = count_q;
    head_id_d = '0;
    status_d  = STATUS_DONE;
    if (cmd.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.pop) begin
      count_d   = count_q - CNT_W'(1);
      head_id_d = head.id;
    end else if (is_remove) begin
      status_d = STATUS_EMPTY;
    end else begin
      status_d = STATUS_FULL;
    end
  end

  spq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .head_o (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response payload; the occupancy shows the count after this word, taken
  // modulo the width of the field.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_id_q <= head_id_d;
      status_q  <= status_d;
      occ_q     <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.head_id   = head_id_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = occ_q;

endmodule

>>> dv/stable_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_checker: prediction and comparison for the queue
// Watches both channels and keeps its own sorted copy of the queue. It works
// out the result of every accepted request word and compares each accepted
// response word, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module stable_priority_queue_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if          req_i,
  spq_rsp_if          rsp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [ID_W-1:0]  head_id;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } sched_result_t;

  // Shadow copy of the queue; slot 0 is the head.
  logic [ID_W-1:0]   shadow_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
  int unsigned       shadow_count;
  sched_result_t     due_results [$];
  sched_result_t     oldest_due;
  int unsigned       mismatches;

  // Applies one request to the shadow queue and returns its result.
  function automatic sched_result_t apply_request(input kind_e             kind,
                                                  input logic [ID_W-1:0]   id,
                                                  input logic [PRIO_W-1:0] prio);
    sched_result_t res;
    int unsigned   slot;
    res.head_id = '0;
    res.status  = STATUS_DONE;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // New entry goes ahead of the first entry of strictly lower class.
        slot = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (slot == shadow_count && prio > shadow_prio[i]) begin
            slot = i;
          end
        end
        for (int i = int'(shadow_count); i > int'(slot); i--) begin
          shadow_id[i]   = shadow_id[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_id[slot]   = id;
        shadow_prio[slot] = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.head_id = shadow_id[0];
      for (int unsigned i = 1; i < shadow_count; i++) begin
        shadow_id[i-1]   = shadow_id[i];
        shadow_prio[i-1] = shadow_prio[i];
      end
      shadow_count--;
    end
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      mismatches   = 0;
      due_results.delete();
    end else begin
      // Requests first, so a response in the same cycle as its request would still find its word.
      if (req_i.valid && req_i.ready) begin
        due_results.push_back(apply_request(kind_e'(req_i.kind), req_i.proc_id,
                                            req_i.prio_class));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_results.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: response word with none due: id %0d st %0d occ %0d",
                     $realtime, rsp_i.head_id, rsp_i.status, rsp_i.occupancy);
          end
          mismatches++;
        end else begin
          oldest_due = due_results.pop_front();
          if (rsp_i.head_id !== oldest_due.head_id ||
              rsp_i.status !== oldest_due.status ||
              rsp_i.occupancy !== oldest_due.occupancy) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: mismatch: id exp %0d got %0d, st exp %0d got %0d, occ exp %0d got %0d",
                       $realtime, oldest_due.head_id, rsp_i.head_id,
                       oldest_due.status, rsp_i.status,
                       oldest_due.occupancy, rsp_i.occupancy);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_cnt_o = mismatches;
    pending_cnt_o  = due_results.size();
  end

endmodule

>>> dv/stable_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit_tb: top of the priority queue testbench
// Drives insert and remove words into the queue, takes its responses with
// random back pressure and lets the checker compare every response word.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned RST_CYCLES   = 12;
  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 5000;
  // The block answers in the cycle after a request; these cycles follow the last phase.
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned quiet_cycles = 0;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  stable_priority_queue_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  stable_priority_queue_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The response side stalls at random; the odds are set per phase below.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang detection: any accepted word on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request word, with random idle cycles ahead of it, and returns
  // at the edge where the block takes it. Valid stays high if the next word
  // follows at once, so it is never dropped and raised in the same step.
  task automatic send_word(input kind_e             kind,
                           input logic [ID_W-1:0]   id,
                           input logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.proc_id    <= id;
    req_if.prio_class <= prio;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Holds the request side quiet until every due response has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // One random phase. The share of inserts steers the fill level: a high
  // share drives the queue into its full state, a low one empties it.
  task automatic run_phase(input int unsigned words, input int unsigned insert_pct,
                           input int unsigned idle_pct, input int unsigned stall_pct);
    kind_e kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) begin
      kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
      send_word(kind, ID_W'($urandom_range(255)), PRIO_W'($urandom_range(3)));
    end
    drain_results();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= KIND_INSERT;
    req_if.proc_id    <= '0;
    req_if.prio_class <= '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A remove on the empty queue must report empty; the
    // ignored fields of removes carry their extremes.
    send_word(KIND_REMOVE, 8'hFF, 2'd3);
    // Lowest class and identifier first, then the highest class must jump
    // to the head. Equal classes must keep arrival order, and a lowest
    // class entry goes behind the earlier one at the tail.
    send_word(KIND_INSERT, 8'h00, 2'd0);
    send_word(KIND_INSERT, 8'hFF, 2'd3);
    send_word(KIND_INSERT, 8'h55, 2'd1);
    send_word(KIND_INSERT, 8'hAA, 2'd1);
    send_word(KIND_INSERT, 8'h12, 2'd2);
    send_word(KIND_INSERT, 8'h34, 2'd3);
    send_word(KIND_INSERT, 8'h56, 2'd0);
    // Empty the queue in priority order, then once more past empty.
    send_word(KIND_REMOVE, 8'h00, 2'd0);
    send_word(KIND_REMOVE, 8'hFF, 2'd3);
    send_word(KIND_REMOVE, 8'hA5, 2'd2);
    send_word(KIND_REMOVE, 8'h5A, 2'd1);
    send_word(KIND_REMOVE, 8'h00, 2'd3);
    send_word(KIND_REMOVE, 8'hFF, 2'd0);
    send_word(KIND_REMOVE, 8'h0F, 2'd1);
    send_word(KIND_REMOVE, 8'hF0, 2'd2);
    // Pause the sender until all responses are back, so the queue is seen
    // both under load and fully quiet.
    drain_results();

    // Random part: fill to full without idling, churn near full with an idle
    // sender, drain to empty with a stalling receiver, then mixed traffic
    // with light idling on both sides.
    run_phase(320, 97, 0, 0);
    run_phase(330, 50, 53, 0);
    run_phase(330, 8, 0, 53);
    run_phase(320, 55, 7, 7);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
